// ===== src/dsrt_pkg.sv =====
// Shared constants for the daily schedule relay timer.
// Used by dsrt_cmp and daily_schedule_relay_timer; no dependencies.
package dsrt_pkg;

  // Default schedule table depth.
  localparam int DEPTH_DEF = 8;

  // Widths of the stored switch time and the configuration field.
  localparam int TIME_W = 17;
  localparam int CFG_W  = 4;

  // Date and time validation limits.
  localparam logic [6:0] YEAR_MIN   = 7'd20;
  localparam logic [6:0] YEAR_MAX   = 7'd30;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] DAY_MAX    = 5'd31;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  // Seconds-of-day weights.
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // Request type codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

endpackage

// ===== src/dsrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dsrt_cmp.sv =====
// Shared time comparator: current time against one stored switch time.
// Depends on dsrt_pkg for the time width.
module dsrt_cmp
  import dsrt_pkg::*;
(
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] ref_time,
  output logic              lt,
  output logic              gt
);

  // One magnitude compare gives both orderings.
  assign lt = now < ref_time;
  assign gt = now > ref_time;

endmodule

// ===== src/daily_schedule_relay_timer.sv =====
// Top level of the daily schedule relay timer: sequencer, table RAM and comparator.
// Depends on dsrt_pkg, dsrt_ram and dsrt_cmp.
// A load, a rejected tick or a table error gives its result in the cycle after start;
// a tick walks from 0 to TABLE_DEPTH-1 table steps and stays busy until it is done,
// since each step reads two switch times through one RAM port.
// Results pulse out_valid for one cycle and cannot be stalled.
// Reset (rst_n low, synchronous) clears state, sent flags, walk index, relay, entry count and results.
module daily_schedule_relay_timer
  import dsrt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // Request channel
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [2:0]       in_entry_index,
  input  logic             in_relay_on,
  input  logic [6:0]       in_year,
  input  logic [3:0]       in_month,
  input  logic [4:0]       in_day,
  input  logic [4:0]       in_hour,
  input  logic [5:0]       in_minute,
  input  logic [5:0]       in_second,
  // Result channel
  output logic             out_valid,
  output logic             out_time_invalid,
  output logic             out_table_error,
  output logic             out_switched,
  output logic             out_relay_level,
  output logic [2:0]       out_fired_entry,
  // Configuration channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_entries_in_use
);

  localparam int WIDX  = $clog2(TABLE_DEPTH);
  localparam int CNT_W = (WIDX > CFG_W) ? WIDX : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_T0,
    S_TLAST,
    S_TI,
    S_TN
  } state_t;

  state_t                 state_r;
  logic [WIDX-1:0]        walk_r;
  logic [WIDX-1:0]        last_r;
  logic [TIME_W-1:0]      now_r;
  logic                   below_r;
  logic                   gt_r;
  logic                   lvl_r;
  logic [TABLE_DEPTH-1:0] sent_r;
  logic                   relay_r;
  logic [CFG_W-1:0]       entries_r;

  logic                   out_valid_r;
  logic                   out_time_invalid_r;
  logic                   out_table_error_r;
  logic                   out_switched_r;
  logic                   out_relay_level_r;
  logic [2:0]             out_fired_entry_r;

  logic                   accept;
  logic                   time_ok;
  logic                   table_ok;
  logic [TIME_W-1:0]      in_secs;
  logic [CNT_W-1:0]       ent_ext;
  logic [CNT_W-1:0]       last_ext;
  logic [WIDX-1:0]        last_nxt;
  logic [WIDX:0]          walk_inc;
  logic [WIDX-1:0]        walk_next;

  logic                   ram_we;
  logic [WIDX-1:0]        ram_waddr;
  logic [TIME_W:0]        ram_wdata;
  logic [WIDX-1:0]        ram_raddr;
  logic [TIME_W:0]        ram_rdata;
  logic [TIME_W-1:0]      rd_time;
  logic                   rd_level;
  logic                   cmp_lt;
  logic                   cmp_gt;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // Date and time validation of the incoming request.
  assign time_ok = (in_year >= YEAR_MIN) && (in_year <= YEAR_MAX) &&
                   (in_month != 4'd0) && (in_month <= MONTH_MAX) &&
                   (in_day != 5'd0) && (in_day <= DAY_MAX) &&
                   (in_hour <= HOUR_MAX) && (in_minute <= MINSEC_MAX) &&
                   (in_second <= MINSEC_MAX);
  assign table_ok = (entries_r >= CFG_W'(2)) && (int'(entries_r) <= TABLE_DEPTH);

  // Seconds of day from the request's time fields.
  assign in_secs = TIME_W'(in_hour) * TIME_W'(SECS_PER_HOUR) +
                   TIME_W'(in_minute) * TIME_W'(SECS_PER_MIN) + TIME_W'(in_second);

  // Index of the last entry in use.
  assign ent_ext  = CNT_W'(entries_r);
  assign last_ext = ent_ext - CNT_W'(1);
  assign last_nxt = last_ext[WIDX-1:0];

  // Walk index on entry to a tick: a stale index restarts at zero.
  assign walk_next = ({1'b0, walk_r} >= {1'b0, last_nxt}) ? '0 : walk_r;
  assign walk_inc  = {1'b0, walk_r} + (WIDX+1)'(1);

  // Table writes come straight from accepted load requests.
  assign ram_we    = accept && (in_req_type == REQ_LOAD) &&
                     (int'(in_entry_index) < TABLE_DEPTH);
  assign ram_waddr = WIDX'(in_entry_index);
  assign ram_wdata = {in_relay_on, in_secs};

  // Read address follows the sequencer state.
  always_comb begin
    unique case (state_r)
      S_IDLE:  ram_raddr = '0;
      S_T0:    ram_raddr = last_r;
      S_TLAST: ram_raddr = walk_r;
      S_TI:    ram_raddr = walk_inc[WIDX-1:0];
      S_TN:    ram_raddr = walk_inc[WIDX-1:0];
      default: ram_raddr = '0;
    endcase
  end

  assign rd_time  = ram_rdata[TIME_W-1:0];
  assign rd_level = ram_rdata[TIME_W];

  dsrt_ram #(
    .WIDTH(TIME_W + 1),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dsrt_cmp u_cmp (
    .now     (now_r),
    .ref_time(rd_time),
    .lt      (cmp_lt),
    .gt      (cmp_gt)
  );

  // Sequencer, schedule state and registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      walk_r             <= '0;
      last_r             <= '0;
      sent_r             <= '0;
      relay_r            <= 1'b0;
      entries_r          <= '0;
      out_valid_r        <= 1'b0;
      out_time_invalid_r <= 1'b0;
      out_table_error_r  <= 1'b0;
      out_switched_r     <= 1'b0;
      out_relay_level_r  <= 1'b0;
      out_fired_entry_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entries_r <= cfg_entries_in_use;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_time_invalid_r <= (in_req_type == REQ_TICK) && !time_ok;
            out_table_error_r  <= (in_req_type == REQ_TICK) && time_ok && !table_ok;
            out_switched_r     <= 1'b0;
            out_relay_level_r  <= relay_r;
            out_fired_entry_r  <= '0;
            now_r              <= in_secs;
            last_r             <= last_nxt;
            if ((in_req_type == REQ_TICK) && time_ok && table_ok) begin
              out_valid_r <= 1'b0;
              walk_r      <= walk_next;
              state_r     <= S_T0;
            end else begin
              // Loads and rejected ticks answer at once.
              out_valid_r <= 1'b1;
            end
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        S_T0: begin
          // First switch time is on the read port.
          below_r <= cmp_lt;
          state_r <= S_TLAST;
        end
        S_TLAST: begin
          // Outside the table span the last entry applies.
          if (below_r || cmp_gt) begin
            if (!sent_r[last_r]) begin
              relay_r           <= rd_level;
              sent_r            <= TABLE_DEPTH'(1) << last_r;
              walk_r            <= '0;
              out_switched_r    <= 1'b1;
              out_relay_level_r <= rd_level;
              out_fired_entry_r <= 3'(last_r);
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_TI;
          end
        end
        S_TI: begin
          // Lower bound of the current interval.
          gt_r    <= cmp_gt;
          lvl_r   <= rd_level;
          state_r <= S_TN;
        end
        S_TN: begin
          // Upper bound decides: fire, step on, or stop.
          if (gt_r && cmp_lt) begin
            if (!sent_r[walk_r]) begin
              relay_r           <= lvl_r;
              sent_r            <= TABLE_DEPTH'(1) << walk_r;
              out_switched_r    <= 1'b1;
              out_relay_level_r <= lvl_r;
              out_fired_entry_r <= 3'(walk_r);
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (!cmp_lt) begin
            if (walk_inc >= {1'b0, last_r}) begin
              walk_r      <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              walk_r  <= walk_inc[WIDX-1:0];
              state_r <= S_TI;
            end
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_time_invalid = out_time_invalid_r;
  assign out_table_error  = out_table_error_r;
  assign out_switched     = out_switched_r;
  assign out_relay_level  = out_relay_level_r;
  assign out_fired_entry  = out_fired_entry_r;

`ifndef SYNTH
  // A result is only issued while the sequencer is idle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result issued while sequencer busy");

  // A fired entry never comes with a rejected request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched) |-> (!out_time_invalid && !out_table_error))
    else $error("fire reported together with an error");

  // At most one entry is marked as sent.
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sent_r))
    else $error("more than one sent flag set");

  // During a walk the index stays below the last entry in use.
  assert property (@(posedge clk) disable iff (!rst_n) busy |-> (walk_r < last_r))
    else $error("walk index beyond last entry");

  // A fire always reports the new relay level.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched) |-> (out_relay_level == relay_r))
    else $error("reported relay level differs from relay state");
`endif

endmodule
